[design/rcta_pkg.sv]
// ----------------------------------------------------------------------------
// rcta_pkg
// Types, constants and the digit-to-character map of the radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcta_pkg;

  localparam int unsigned ValueBits = 63;
  localparam int unsigned RadixBits = 5;
  localparam int unsigned CharBits  = 7;
  localparam int unsigned DigitBits = 4;

  localparam logic [RadixBits-1:0] RadixMin  = 5'd2;
  localparam logic [RadixBits-1:0] RadixMax  = 5'd16;
  localparam logic [CharBits-1:0]  AsciiZero = 7'h30;
  localparam logic [CharBits-1:0]  AsciiA    = 7'h41;
  localparam logic [DigitBits-1:0] DecLimit  = 4'd10;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [RadixBits-1:0] radix;
  } in_item_t;

  typedef struct packed {
    logic [CharBits-1:0] digit_char;
    logic                last;
    logic                bad_base;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic                 done;
    logic                 quot_zero;
    logic [DigitBits-1:0] rem;
  } div_stat_t;

  function automatic logic [CharBits-1:0] digit_to_ascii(input logic [DigitBits-1:0] d);
    logic [CharBits-1:0] res;
    if (d < DecLimit) begin
      res = AsciiZero + {3'b000, d};
    end else begin
      res = AsciiA + {3'b000, d - DecLimit};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/rcta_ram.sv]
// ----------------------------------------------------------------------------
// rcta_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcta_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/rcta_divider.sv]
// ----------------------------------------------------------------------------
// rcta_divider
// Bit-serial restoring divider: one quotient bit per cycle, the quotient
// replaces the dividend in place so repeated starts peel off digits.
// ----------------------------------------------------------------------------
`default_nettype none

module rcta_divider
  import rcta_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 63
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire div_ctrl_t              ctrl_i,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic [RadixBits-1:0]   radix_i,
  output div_stat_t                   stat_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [RadixBits-1:0]   radix_q, radix_d;
  logic [DigitBits-1:0]   rem_q, rem_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   nz_q, nz_d;
  logic [RadixBits-1:0]   trial;
  logic [RadixBits-1:0]   diff;
  logic                   ge;

  assign trial = {rem_q, val_q[VALUE_WIDTH-1]};
  assign ge    = (trial >= radix_q);
  assign diff  = trial - radix_q;

  always_comb begin
    val_d   = val_q;
    radix_d = radix_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    nz_d    = nz_q;
    if (ctrl_i.load) begin
      val_d   = value_i;
      radix_d = radix_i;
    end
    if (ctrl_i.start) begin
      rem_d  = '0;
      cnt_d  = CntW'(VALUE_WIDTH);
      busy_d = 1'b1;
      nz_d   = 1'b0;
    end else if (busy_q) begin
      val_d = {val_q[VALUE_WIDTH-2:0], ge};
      rem_d = ge ? diff[DigitBits-1:0] : trial[DigitBits-1:0];
      nz_d  = nz_q | ge;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    radix_q <= radix_d;
    rem_q   <= rem_d;
    nz_q    <= nz_d;
  end

  assign stat_o.done      = done_q;
  assign stat_o.quot_zero = ~nz_q;
  assign stat_o.rem       = rem_q;

endmodule

`default_nettype wire

[design/radix_converter_to_ascii.sv]
// ----------------------------------------------------------------------------
// radix_converter_to_ascii
// Converts a non-negative integer to its digit string in base 2..16,
// emitted most significant digit first as ASCII characters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_ready_o     | in_data_i  (value, radix)
//  out     | output    | out_valid_o / out_ready_i   | out_data_o (digit_char, last, bad_base)
//
//  each digit comes from a full pass of the bit-serial divider
//  then each result is read back from the digit store via ST_FETCH and ST_LOAD
//  a bad base gives its single result in the cycle after acceptance
//  one conversion at a time; in_ready_o is high only between conversions
//  reset clears the control state; the digit store needs no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module radix_converter_to_ascii
  import rcta_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = 64,
  parameter int unsigned VALUE_WIDTH = 63
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned AddrW = $clog2(MAX_DIGITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_LOAD,
    ST_SEND
  } state_e;

  state_e               state_q;
  logic [AddrW-1:0]     wptr_q;
  logic [AddrW-1:0]     idx_q;
  logic                 out_valid_q;
  out_item_t            out_data_q;
  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic                 in_acc;
  logic                 radix_bad;
  logic                 div_stop;
  logic [DigitBits-1:0] rdata;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign radix_bad = (in_data_i.radix < RadixMin) || (in_data_i.radix > RadixMax);
  assign div_stop  = div_stat.quot_zero || (wptr_q == AddrW'(MAX_DIGITS - 1));

  always_comb begin
    div_ctrl.load  = in_acc && !radix_bad;
    div_ctrl.start = div_ctrl.load
                     || ((state_q == ST_DIV) && div_stat.done && !div_stop);
  end

  rcta_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .value_i(in_data_i.value[VALUE_WIDTH-1:0]),
    .radix_i(in_data_i.radix),
    .stat_o (div_stat)
  );

  rcta_ram #(
    .WIDTH(DigitBits),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   ((state_q == ST_DIV) && div_stat.done),
    .waddr_i(wptr_q),
    .wdata_i(div_stat.rem),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            wptr_q <= '0;
            if (radix_bad) begin
              idx_q                 <= '0;
              out_data_q.digit_char <= '0;
              out_data_q.last       <= 1'b1;
              out_data_q.bad_base   <= 1'b1;
              out_valid_q           <= 1'b1;
              state_q               <= ST_SEND;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (div_stop) begin
              idx_q   <= wptr_q;
              state_q <= ST_FETCH;
            end else begin
              wptr_q <= wptr_q + 1'b1;
            end
          end
        end
        ST_FETCH: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          out_data_q.digit_char <= digit_to_ascii(rdata);
          out_data_q.last       <= (idx_q == '0);
          out_data_q.bad_base   <= 1'b0;
          out_valid_q           <= 1'b1;
          state_q               <= ST_SEND;
        end
        ST_SEND: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= ST_FETCH;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[design/rcta_checker.sv]
// ----------------------------------------------------------------------------
// rcta_checker
// Port-level checks on the radix converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcta_checker
  import rcta_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one conversion at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new transaction taken during conversion");

  a_no_input_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // bad base result is a lone flagged transaction
  a_bad_base_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_base |-> out_data_o.last && (out_data_o.digit_char == '0))
    else $error("bad base result malformed");

  // more digits follow a non-final result
  a_more_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> !in_ready_o)
    else $error("conversion ended before last digit");

endmodule

bind radix_converter_to_ascii rcta_checker u_rcta_checker (.*);

`default_nettype wire
